>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons holds whenever ante holds.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/kf2_pkg.sv
// Shared constants, codes, types and arithmetic helpers of the 2-D Kalman filter.
// Used by kf2_mul, kf2_div and the top level; depends on nothing.
package kf2_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int CFG_W     = 31;
	localparam int DT_W      = 20;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int ACC_W     = 66 - FRAC_BITS;
	localparam int SAT_W     = 66;
	localparam int DET_W     = 65;
	localparam int MAG_W     = (DATA_W + FRAC_BITS > 64 - FRAC_BITS) ?
	                           (DATA_W + FRAC_BITS) : (64 - FRAC_BITS);
	localparam int DIV_W     = MAG_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(65536);

	// Action codes of an input item.
	localparam logic [1:0] ACT_INIT    = 2'd0;
	localparam logic [1:0] ACT_PREDICT = 2'd1;
	localparam logic [1:0] ACT_UPDATE  = 2'd2;
	localparam logic [1:0] ACT_NONE    = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_PVX   = 3'd0;
	localparam logic [2:0] REG_PVY   = 3'd1;
	localparam logic [2:0] REG_MVX   = 3'd2;
	localparam logic [2:0] REG_MVY   = 3'd3;
	localparam logic [2:0] REG_PINIT = 3'd4;

	localparam logic signed [SAT_W-1:0] SAT_MAX = (SAT_W'(1) <<< (DATA_W - 1)) - SAT_W'(1);
	localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_MAX - SAT_W'(1);
	localparam logic signed [SAT_W-1:0] ONE_S   = SAT_W'(1) <<< FRAC_BITS;

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic  clip;
		data_t val;
	} sat_t;

	typedef struct packed {
		logic                    start;
		logic signed [DIV_W-1:0] num;
		logic signed [DIV_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [DIV_W-1:0] quo;
	} div_rsp_t;

	// Clip a wide signed value to the 32-bit range and flag clipping.
	function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
		sat_t r;
		r.clip = 1'b0;
		r.val  = v[DATA_W-1:0];
		if (v > SAT_MAX) begin
			r.clip = 1'b1;
			r.val  = SAT_MAX[DATA_W-1:0];
		end else if (v < SAT_MIN) begin
			r.clip = 1'b1;
			r.val  = SAT_MIN[DATA_W-1:0];
		end
		return r;
	endfunction

	// Rescale a full product back to Q format, rounding half up.
	function automatic logic signed [ACC_W-1:0] mq(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + (PROD_W'(1) <<< (FRAC_BITS - 1));
		return ACC_W'(t >>> FRAC_BITS);
	endfunction

endpackage

>>> rtl/kf2_mul.sv
// Shared 32x32 signed multiplier with a registered product.
// Depends on kf2_pkg.
module kf2_mul (
	input  logic                                   clk,
	input  kf2_pkg::data_t                         a,
	input  kf2_pkg::data_t                         b,
	output logic signed [kf2_pkg::PROD_W-1:0]      prod
);

	logic signed [kf2_pkg::PROD_W-1:0] prod_q;

	// One product per cycle, available on the following cycle.
	always_ff @(posedge clk) begin
		prod_q <= kf2_pkg::PROD_W'(a) * kf2_pkg::PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

>>> rtl/kf2_div.sv
// Bit-serial signed divider, truncating toward zero, one quotient bit a cycle.
// Depends on kf2_pkg.
module kf2_div (
	input  logic               clk,
	input  logic               arst_n,
	input  kf2_pkg::div_req_t  req,
	output kf2_pkg::div_rsp_t  rsp
);

	localparam int W = kf2_pkg::DIV_W;

	logic                             busy_q;
	logic                             done_q;
	logic [kf2_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [W-1:0]                     rem_q;
	logic [W-1:0]                     nq_q;
	logic [W-1:0]                     dmag_q;
	logic                             neg_q;
	logic [W-1:0]                     num_mag;
	logic [W-1:0]                     den_mag;
	logic [W:0]                       trial;
	logic [W:0]                       diff;
	logic                             ge;

	// Operand magnitudes; the quotient sign is restored at the end.
	assign num_mag = req.num[W-1] ? W'(-req.num) : W'(req.num);
	assign den_mag = req.den[W-1] ? W'(-req.den) : W'(req.den);

	// Restoring step: shift in the next dividend bit and try a subtract.
	assign trial = {rem_q, nq_q[W-1]};
	assign diff  = trial - {1'b0, dmag_q};
	assign ge    = trial >= {1'b0, dmag_q};

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= kf2_pkg::DIV_CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == kf2_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient datapath.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			nq_q   <= num_mag;
			dmag_q <= den_mag;
			neg_q  <= req.num[W-1] ^ req.den[W-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
			nq_q  <= {nq_q[W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? -$signed(nq_q) : $signed(nq_q);

endmodule

>>> rtl/kalman_filter_2d_position_top.sv
// Two-state Kalman filter with identity transition and observation, Q16.16 signed.
// Depends on kf2_pkg, kf2_mul, kf2_div and assert_macros.svh.
//
// One item is taken at a time and in_stall stays high until its result has been
// moved to the output register. The four entries of the inverse innovation
// covariance, in Q16.16, each go through the bit-serial divider, and every matrix
// product runs through the one shared multiplier. A new item may be accepted
// while the previous result still waits on out_stall.
module kalman_filter_2d_position_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic signed [31:0]            u_x,
	input  logic signed [31:0]            u_y,
	input  logic [19:0]                   dt,
	input  logic signed [31:0]            z_x,
	input  logic signed [31:0]            z_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [31:0]            est_x,
	output logic signed [31:0]            est_y,
	output logic signed [31:0]            cov_00,
	output logic signed [31:0]            cov_01,
	output logic signed [31:0]            cov_10,
	output logic signed [31:0]            cov_11,
	output logic                          singular,
	output logic                          saturated,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [30:0]                   cfg_data
);

	`include "assert_macros.svh"

	localparam int SW = kf2_pkg::SAT_W;

	// Kinds of product sum run on the shared multiplier.
	localparam logic [1:0] KIND_PRED = 2'd0;
	localparam logic [1:0] KIND_K    = 2'd1;
	localparam logic [1:0] KIND_EST  = 2'd2;
	localparam logic [1:0] KIND_PN   = 2'd3;

	// Sequencer states.
	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_INIT     = 5'd1;
	localparam logic [4:0] ST_PCOV     = 5'd2;
	localparam logic [4:0] ST_SFORM    = 5'd3;
	localparam logic [4:0] ST_DET_A    = 5'd4;
	localparam logic [4:0] ST_DET_B    = 5'd5;
	localparam logic [4:0] ST_DET_C    = 5'd6;
	localparam logic [4:0] ST_DET_D    = 5'd7;
	localparam logic [4:0] ST_DIV_GO   = 5'd8;
	localparam logic [4:0] ST_DIV_WAIT = 5'd9;
	localparam logic [4:0] ST_MUL      = 5'd10;
	localparam logic [4:0] ST_ACC      = 5'd11;
	localparam logic [4:0] ST_WR       = 5'd12;
	localparam logic [4:0] ST_YFORM    = 5'd13;
	localparam logic [4:0] ST_MFORM    = 5'd14;
	localparam logic [4:0] ST_COPY     = 5'd15;
	localparam logic [4:0] ST_OUT      = 5'd16;

	logic [4:0]                            state_q;
	logic [1:0]                            kind_q;
	logic [1:0]                            e_q;
	logic                                  t_q;
	logic [1:0]                            act_q;
	kf2_pkg::data_t                        ux_q, uy_q, zx_q, zy_q;
	logic [kf2_pkg::DT_W-1:0]              dt_q;
	kf2_pkg::data_t                        est_q [2];
	kf2_pkg::data_t                        cov_q [4];
	kf2_pkg::data_t                        s_q [4];
	kf2_pkg::data_t                        sinv_q [4];
	kf2_pkg::data_t                        kk_q [4];
	kf2_pkg::data_t                        m_q [4];
	kf2_pkg::data_t                        y_q [2];
	logic signed [kf2_pkg::ACC_W-1:0]      acc_q;
	logic signed [kf2_pkg::DET_W-1:0]      det_q;
	logic signed [kf2_pkg::DIV_W-1:0]      detq_q;
	logic                                  clip_q;
	logic                                  sing_q;
	logic [kf2_pkg::CFG_W-1:0]             pvx_q, pvy_q, mvx_q, mvy_q, pinit_q;
	logic                                  out_valid_q;
	kf2_pkg::data_t                        o_est_q [2];
	kf2_pkg::data_t                        o_cov_q [4];
	logic                                  o_sing_q;
	logic                                  o_sat_q;

	kf2_pkg::data_t                        mul_a, mul_b;
	logic signed [kf2_pkg::PROD_W-1:0]     prod;
	logic [1:0]                            cov_idx;
	kf2_pkg::data_t                        cov_rd, sinv_rd, kk_rd, m_rd, y_rd, est_rd;
	logic [1:0]                            s_idx;
	kf2_pkg::data_t                        s_rd;
	logic signed [kf2_pkg::DATA_W:0]       adj_ext, adj;
	kf2_pkg::div_req_t                     div_req;
	kf2_pkg::div_rsp_t                     div_rsp;
	kf2_pkg::sat_t                         quo_sat, wr_sat;
	kf2_pkg::sat_t                         s0_sat, s3_sat, y0_sat, y1_sat;
	kf2_pkg::sat_t                         m0_sat, m1_sat, m2_sat, m3_sat;
	kf2_pkg::sat_t                         pc0_sat, pc3_sat;
	logic signed [SW-1:0]                  wr_base;
	logic signed [kf2_pkg::DET_W-1:0]      det_adj, detq_full;
	logic signed [kf2_pkg::DIV_W-1:0]      detq_new;
	logic [1:0]                            last_e;
	logic                                  last_t;
	logic                                  out_load;

	// Register file writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvx_q   <= kf2_pkg::CFG_RESET;
			pvy_q   <= kf2_pkg::CFG_RESET;
			mvx_q   <= kf2_pkg::CFG_RESET;
			mvy_q   <= kf2_pkg::CFG_RESET;
			pinit_q <= kf2_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kf2_pkg::REG_PVX:   pvx_q   <= cfg_data;
				kf2_pkg::REG_PVY:   pvy_q   <= cfg_data;
				kf2_pkg::REG_MVX:   mvx_q   <= cfg_data;
				kf2_pkg::REG_MVY:   mvy_q   <= cfg_data;
				kf2_pkg::REG_PINIT: pinit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operand reads, one address per array.
	assign cov_idx = (kind_q == KIND_K) ? {e_q[1], t_q} : {t_q, e_q[0]};
	assign cov_rd  = cov_q[cov_idx];
	assign sinv_rd = sinv_q[{t_q, e_q[0]}];
	assign kk_rd   = kk_q[{e_q[0], t_q}];
	assign m_rd    = m_q[{e_q[1], t_q}];
	assign y_rd    = y_q[t_q];
	assign est_rd  = est_q[e_q[0]];

	// Multiplier operand selection.
	always_comb begin
		mul_a = s_q[0];
		mul_b = s_q[3];
		if (state_q == ST_DET_B) begin
			mul_a = s_q[1];
			mul_b = s_q[2];
		end else if (state_q != ST_DET_A) begin
			unique case (kind_q)
				KIND_PRED: begin
					mul_a = kf2_pkg::DATA_W'(dt_q);
					mul_b = e_q[0] ? uy_q : ux_q;
				end
				KIND_K: begin
					mul_a = cov_rd;
					mul_b = sinv_rd;
				end
				KIND_EST: begin
					mul_a = kk_rd;
					mul_b = y_rd;
				end
				KIND_PN: begin
					mul_a = m_rd;
					mul_b = cov_rd;
				end
				default: ;
			endcase
		end
	end

	kf2_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Adjugate entry for the current divide: S11, -S01, -S10, S00.
	assign s_idx   = e_q ^ {2{e_q[0] == e_q[1]}};
	assign s_rd    = s_q[s_idx];
	assign adj_ext = (kf2_pkg::DATA_W + 1)'(s_rd);
	assign adj     = (e_q[0] ^ e_q[1]) ? -adj_ext : adj_ext;

	assign div_req.start = (state_q == ST_DIV_GO);
	assign div_req.num   = kf2_pkg::DIV_W'(adj) <<< kf2_pkg::FRAC_BITS;
	assign div_req.den   = detq_q;

	kf2_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign quo_sat = kf2_pkg::sat32(SW'(div_rsp.quo));

	// Scaled determinant, truncated toward zero.
	assign det_adj   = det_q + (det_q[kf2_pkg::DET_W-1] ?
	                   kf2_pkg::DET_W'((1 << kf2_pkg::FRAC_BITS) - 1) : kf2_pkg::DET_W'(0));
	assign detq_full = det_adj >>> kf2_pkg::FRAC_BITS;
	assign detq_new  = detq_full[kf2_pkg::DIV_W-1:0];

	// Element write-back of a product sum.
	assign wr_base = ((kind_q == KIND_PRED) || (kind_q == KIND_EST)) ? SW'(est_rd) : '0;
	assign wr_sat  = kf2_pkg::sat32(SW'(acc_q) + wr_base);
	assign last_e  = ((kind_q == KIND_PRED) || (kind_q == KIND_EST)) ? 2'd1 : 2'd3;
	assign last_t  = (kind_q != KIND_PRED);

	// Single-step element updates.
	assign pc0_sat = kf2_pkg::sat32(SW'(cov_q[0]) + SW'(pvx_q));
	assign pc3_sat = kf2_pkg::sat32(SW'(cov_q[3]) + SW'(pvy_q));
	assign s0_sat  = kf2_pkg::sat32(SW'(cov_q[0]) + SW'(mvx_q));
	assign s3_sat  = kf2_pkg::sat32(SW'(cov_q[3]) + SW'(mvy_q));
	assign y0_sat  = kf2_pkg::sat32(SW'(zx_q) - SW'(est_q[0]));
	assign y1_sat  = kf2_pkg::sat32(SW'(zy_q) - SW'(est_q[1]));
	assign m0_sat  = kf2_pkg::sat32(kf2_pkg::ONE_S - SW'(kk_q[0]));
	assign m1_sat  = kf2_pkg::sat32(-SW'(kk_q[1]));
	assign m2_sat  = kf2_pkg::sat32(-SW'(kk_q[2]));
	assign m3_sat  = kf2_pkg::sat32(kf2_pkg::ONE_S - SW'(kk_q[3]));

	assign in_stall = (state_q != ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// Sequencer and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			kind_q   <= KIND_PRED;
			e_q      <= '0;
			t_q      <= 1'b0;
			clip_q   <= 1'b0;
			sing_q   <= 1'b0;
			est_q[0] <= '0;
			est_q[1] <= '0;
			cov_q[0] <= '0;
			cov_q[1] <= '0;
			cov_q[2] <= '0;
			cov_q[3] <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						clip_q <= 1'b0;
						sing_q <= 1'b0;
						kind_q <= KIND_PRED;
						e_q    <= '0;
						t_q    <= 1'b0;
						unique case (action)
							kf2_pkg::ACT_INIT:    state_q <= ST_INIT;
							kf2_pkg::ACT_PREDICT: state_q <= ST_MUL;
							kf2_pkg::ACT_UPDATE:  state_q <= ST_SFORM;
							default:              state_q <= ST_OUT;
						endcase
					end
				end
				ST_INIT: begin
					est_q[0] <= zx_q;
					est_q[1] <= zy_q;
					cov_q[0] <= kf2_pkg::DATA_W'(pinit_q);
					cov_q[1] <= '0;
					cov_q[2] <= '0;
					cov_q[3] <= kf2_pkg::DATA_W'(pinit_q);
					state_q  <= ST_OUT;
				end
				ST_PCOV: begin
					cov_q[0] <= pc0_sat.val;
					cov_q[3] <= pc3_sat.val;
					clip_q   <= clip_q | pc0_sat.clip | pc3_sat.clip;
					state_q  <= ST_OUT;
				end
				ST_SFORM: begin
					clip_q  <= clip_q | s0_sat.clip | s3_sat.clip;
					state_q <= ST_DET_A;
				end
				ST_DET_A: state_q <= ST_DET_B;
				ST_DET_B: state_q <= ST_DET_C;
				ST_DET_C: state_q <= ST_DET_D;
				ST_DET_D: begin
					e_q <= '0;
					if (detq_new == '0) begin
						sing_q  <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO: state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						clip_q <= clip_q | quo_sat.clip;
						if (e_q == 2'd3) begin
							kind_q  <= KIND_K;
							e_q     <= '0;
							t_q     <= 1'b0;
							state_q <= ST_MUL;
						end else begin
							e_q     <= e_q + 1'b1;
							state_q <= ST_DIV_GO;
						end
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (t_q == last_t) begin
						state_q <= ST_WR;
					end else begin
						t_q     <= 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_WR: begin
					clip_q <= clip_q | wr_sat.clip;
					t_q    <= 1'b0;
					unique case (kind_q)
						KIND_PRED, KIND_EST: est_q[e_q[0]] <= wr_sat.val;
						default: ;
					endcase
					if (e_q == last_e) begin
						e_q <= '0;
						unique case (kind_q)
							KIND_PRED: state_q <= ST_PCOV;
							KIND_K:    state_q <= ST_YFORM;
							KIND_EST:  state_q <= ST_MFORM;
							default:   state_q <= ST_COPY;
						endcase
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_YFORM: begin
					clip_q  <= clip_q | y0_sat.clip | y1_sat.clip;
					kind_q  <= KIND_EST;
					state_q <= ST_MUL;
				end
				ST_MFORM: begin
					clip_q  <= clip_q | m0_sat.clip | m1_sat.clip | m2_sat.clip | m3_sat.clip;
					kind_q  <= KIND_PN;
					state_q <= ST_MUL;
				end
				ST_COPY: begin
					cov_q[0] <= kk_q[0];
					cov_q[1] <= kk_q[1];
					cov_q[2] <= kk_q[2];
					cov_q[3] <= kk_q[3];
					state_q  <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && in_valid) begin
			act_q <= action;
			ux_q  <= u_x;
			uy_q  <= u_y;
			dt_q  <= dt;
			zx_q  <= z_x;
			zy_q  <= z_y;
			acc_q <= '0;
		end
		unique case (state_q)
			ST_SFORM: begin
				s_q[0] <= s0_sat.val;
				s_q[1] <= cov_q[1];
				s_q[2] <= cov_q[2];
				s_q[3] <= s3_sat.val;
			end
			ST_DET_B: det_q <= kf2_pkg::DET_W'(prod);
			ST_DET_C: det_q <= det_q - kf2_pkg::DET_W'(prod);
			ST_DET_D: detq_q <= detq_new;
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					sinv_q[e_q] <= quo_sat.val;
				end
				acc_q <= '0;
			end
			ST_ACC: acc_q <= acc_q + kf2_pkg::mq(prod);
			ST_WR: begin
				acc_q <= '0;
				if ((kind_q == KIND_K) || (kind_q == KIND_PN)) begin
					kk_q[e_q] <= wr_sat.val;
				end
			end
			ST_YFORM: begin
				y_q[0] <= y0_sat.val;
				y_q[1] <= y1_sat.val;
			end
			ST_MFORM: begin
				m_q[0] <= m0_sat.val;
				m_q[1] <= m1_sat.val;
				m_q[2] <= m2_sat.val;
				m_q[3] <= m3_sat.val;
			end
			default: ;
		endcase
	end

	// Output register, freeing the core while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_est_q[0] <= est_q[0];
			o_est_q[1] <= est_q[1];
			o_cov_q[0] <= cov_q[0];
			o_cov_q[1] <= cov_q[1];
			o_cov_q[2] <= cov_q[2];
			o_cov_q[3] <= cov_q[3];
			o_sing_q   <= sing_q;
			o_sat_q    <= clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign est_x     = o_est_q[0];
	assign est_y     = o_est_q[1];
	assign cov_00    = o_cov_q[0];
	assign cov_01    = o_cov_q[1];
	assign cov_10    = o_cov_q[2];
	assign cov_11    = o_cov_q[3];
	assign singular  = o_sing_q;
	assign saturated = o_sat_q;

	// A divider result only arrives while the sequencer waits for it.
	`ASSERT_IMPL(a_div_done_in_wait, div_rsp.done, state_q == ST_DIV_WAIT, "divider done outside wait")
	// The singular flag is only raised by an update item.
	`ASSERT_IMPL(a_sing_update, (state_q == ST_OUT) && sing_q, act_q == kf2_pkg::ACT_UPDATE, "singular without update")
	// An accepted item always moves the sequencer out of idle.
	`ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_q != ST_IDLE, "item accepted but idle")

endmodule
